/* rtl/sbc_pkg.sv */
package sbc_pkg;

   // Table size and coordinate format
   localparam int MaxBodies  = 32;
   localparam int CoordBits  = 16;
   localparam int RadiusBits = 15;
   localparam int AttrBits   = 32;
   localparam int IdxBits    = $clog2(MaxBodies);
   localparam int CntBits    = $clog2(MaxBodies + 2);
   localparam int OutIdxBits = 5;

   // Arithmetic widths of the pair test
   localparam int DiffBits  = CoordBits + 1;
   localparam int MagBits   = CoordBits;
   localparam int SqBits    = 2 * MagBits;
   localparam int SumBits   = SqBits + 2;
   localparam int LimBits   = RadiusBits + 1;
   localparam int LimSqBits = 2 * LimBits;
   localparam int CmpBits   = (SumBits > LimSqBits) ? SumBits : LimSqBits;

   // Request payload layout
   localparam int OffActive  = 2;
   localparam int OffAttr    = 3;
   localparam int OffMask    = OffAttr + AttrBits;
   localparam int OffPos     = OffMask + AttrBits;
   localparam int OffExt     = OffPos + 3 * CoordBits;
   localparam int OffRad     = OffExt + 3 * CoordBits;
   localparam int ReqRawBits = OffRad + RadiusBits;
   localparam int ReqDataBits = ((ReqRawBits + 7) / 8) * 8;
   localparam int RspDataBits = ((2 * OutIdxBits + 7) / 8) * 8;

   // Codes
   localparam logic [1:0] ShapeSphere = 2'd0;
   localparam logic [1:0] ShapeBox    = 2'd1;
   localparam logic       OpRegister  = 1'b0;
   localparam logic       OpClear     = 1'b1;

   typedef logic signed [CoordBits-1:0] coord_type;

   typedef struct packed {
      logic [1:0]            shape;
      logic                  active;
      logic [AttrBits-1:0]   attr;
      logic [AttrBits-1:0]   accept;
      coord_type             lo_x;
      coord_type             lo_y;
      coord_type             lo_z;
      coord_type             hi_x;
      coord_type             hi_y;
      coord_type             hi_z;
      logic [RadiusBits-1:0] radius;
   } body_type;

   typedef struct packed {
      logic               live;
      logic               fin;
      logic [IdxBits-1:0] idx;
      logic               hit;
   } token_type;

endpackage

/* rtl/sbc_cell.sv */
module sbc_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  logic              wr_en,
   input  sbc_pkg::body_type wr_body,
   input  sbc_pkg::body_type next_body,
   output sbc_pkg::body_type body
);
   import sbc_pkg::*;

   body_type body_ff;
   body_type body_in;

   // Load a new body, or take the neighbor's body while the ring turns
   always_comb begin
      body_in = body_ff;
      if (wr_en) begin
         body_in = wr_body;
      end else if (shift_en) begin
         body_in = next_body;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
   end

   assign body = body_ff;

endmodule

/* rtl/sbc_pair_test.sv */
module sbc_pair_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  sbc_pkg::token_type tok_in,
   input  sbc_pkg::body_type  probe,
   input  sbc_pkg::body_type  other,
   output sbc_pkg::token_type tok_out
);
   import sbc_pkg::*;

   token_type              tok1_ff, tok1_in, tok2_ff, tok3_ff, tok3_in;
   logic                   gate1_ff, gate1_in, gate2_ff;
   logic                   dist1_ff, dist1_in, dist2_ff;
   logic                   bb1_ff, bb1_in, bb2_ff;
   logic [MagBits-1:0]     mag_ff [3];
   logic [MagBits-1:0]     mag_in [3];
   logic [LimBits-1:0]     lim_ff, lim_in;
   logic [SqBits-1:0]      sq_ff [3];
   logic [LimSqBits-1:0]   limsq_ff;
   logic [CmpBits-1:0]     sum;

   coord_type              a_lo [3], a_hi [3], b_lo [3], b_hi [3];
   coord_type              c [3], blo [3], bhi [3], p [3];
   logic signed [DiffBits-1:0] d [3];
   logic                   ss, bb, sbx, a_sph, overlap;

   assign a_lo = '{probe.lo_x, probe.lo_y, probe.lo_z};
   assign a_hi = '{probe.hi_x, probe.hi_y, probe.hi_z};
   assign b_lo = '{other.lo_x, other.lo_y, other.lo_z};
   assign b_hi = '{other.hi_x, other.hi_y, other.hi_z};

   // Stage one: gate the pair, pick the test, form per-axis distances
   always_comb begin
      ss    = (probe.shape == ShapeSphere) && (other.shape == ShapeSphere);
      bb    = (probe.shape == ShapeBox) && (other.shape == ShapeBox);
      a_sph = (probe.shape == ShapeSphere);
      sbx   = ((probe.shape == ShapeSphere) && (other.shape == ShapeBox)) ||
              ((probe.shape == ShapeBox) && (other.shape == ShapeSphere));
      overlap = 1'b1;
      for (int k = 0; k < 3; k++) begin
         if ((a_hi[k] < b_lo[k]) || (a_lo[k] > b_hi[k])) begin
            overlap = 1'b0;
         end
         c[k]   = a_sph ? a_lo[k] : b_lo[k];
         blo[k] = a_sph ? b_lo[k] : a_lo[k];
         bhi[k] = a_sph ? b_hi[k] : a_hi[k];
         if (c[k] < blo[k]) begin
            p[k] = blo[k];
         end else if (c[k] > bhi[k]) begin
            p[k] = bhi[k];
         end else begin
            p[k] = c[k];
         end
         if (ss) begin
            d[k] = {a_lo[k][CoordBits-1], a_lo[k]} - {b_lo[k][CoordBits-1], b_lo[k]};
         end else begin
            d[k] = {c[k][CoordBits-1], c[k]} - {p[k][CoordBits-1], p[k]};
         end
         mag_in[k] = (d[k] < 0) ? MagBits'(-d[k]) : MagBits'(d[k]);
      end
      if (ss) begin
         lim_in = {1'b0, probe.radius} + {1'b0, other.radius};
      end else begin
         lim_in = a_sph ? {1'b0, probe.radius} : {1'b0, other.radius};
      end
      gate1_in = probe.active && other.active &&
                 ((probe.attr & other.accept) != '0) &&
                 ((other.attr & probe.accept) != '0);
      dist1_in = ss || sbx;
      bb1_in   = bb && overlap;
      tok1_in  = tok_in;
   end

   // Stage three: sum of squares against the squared limit
   always_comb begin
      sum = CmpBits'(sq_ff[0]) + CmpBits'(sq_ff[1]) + CmpBits'(sq_ff[2]);
      tok3_in = tok2_ff;
      tok3_in.hit = tok2_ff.live && gate2_ff &&
                    (bb2_ff || (dist2_ff && (sum <= CmpBits'(limsq_ff))));
   end

   // Advance tokens through the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         tok1_ff <= '0;
         tok2_ff <= '0;
         tok3_ff <= '0;
      end else if (en) begin
         tok1_ff <= tok1_in;
         tok2_ff <= tok1_ff;
         tok3_ff <= tok3_in;
      end
   end

   // Payload stages: distances, then squares
   always_ff @(posedge clock) begin
      if (en) begin
         gate1_ff <= gate1_in;
         dist1_ff <= dist1_in;
         bb1_ff   <= bb1_in;
         lim_ff   <= lim_in;
         mag_ff   <= mag_in;
         gate2_ff <= gate1_ff;
         dist2_ff <= dist1_ff;
         bb2_ff   <= bb1_ff;
         limsq_ff <= lim_ff * lim_ff;
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= mag_ff[k] * mag_ff[k];
         end
      end
   end

   assign tok_out = tok3_ff;

endmodule

/* rtl/sphere_box_pair_collider_top.sv */
// A register item gives its final result when its scan of the body ring ends; a hit that
// is not the last can leave before the scan ends.
// A register item takes one full turn of the body ring, one stored body per cycle into the
// pair test while the output does not stall; no new request is taken until its scan is over.
// Clear and overflow items start no scan. Output stalls hold the whole ring.
// Reset (synchronous, active high) empties the table; stored bodies are not cleared.
module sphere_box_pair_collider_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // shape, active, attribute, mask, pos_x, pos_y, pos_z, ext_x, ext_y, ext_z, radius
   input  logic [sbc_pkg::ReqDataBits-1:0] req_tdata,
   // opcode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // earlier_index, new_index
   output logic [sbc_pkg::RspDataBits-1:0] rsp_tdata,
   // hit, overflow
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);
   import sbc_pkg::*;

   body_type           ring [MaxBodies];
   body_type           req_body, probe_ff, probe_in;
   token_type          tok_in, tok_out;
   logic               adv, acc, reg_ok, reg_full, shift, issue;
   logic               busy_ff, busy_in;
   logic [CntBits-1:0] count_ff, count_in, cnt_ff, cnt_in, n_ff, n_in;
   logic               pend_v_ff, pend_v_in;
   logic [IdxBits-1:0] pend_ff, pend_in;
   logic               rv_ff, rv_in, rhit_ff, rhit_in, rovf_ff, rovf_in, rlast_ff, rlast_in;
   logic [OutIdxBits-1:0] rearly_ff, rearly_in, rnew_ff, rnew_in;

   // Unpack the request payload
   assign req_body.shape  = req_tdata[1:0];
   assign req_body.active = req_tdata[OffActive];
   assign req_body.attr   = req_tdata[OffAttr +: AttrBits];
   assign req_body.accept = req_tdata[OffMask +: AttrBits];
   assign req_body.lo_x   = req_tdata[OffPos +: CoordBits];
   assign req_body.lo_y   = req_tdata[OffPos + CoordBits +: CoordBits];
   assign req_body.lo_z   = req_tdata[OffPos + 2 * CoordBits +: CoordBits];
   assign req_body.hi_x   = req_tdata[OffExt +: CoordBits];
   assign req_body.hi_y   = req_tdata[OffExt + CoordBits +: CoordBits];
   assign req_body.hi_z   = req_tdata[OffExt + 2 * CoordBits +: CoordBits];
   assign req_body.radius = req_tdata[OffRad +: RadiusBits];

   // Handshake and scan control
   assign adv        = !rv_ff || rsp_tready;
   assign req_tready = !busy_ff && adv;
   assign acc        = req_tvalid && req_tready;
   assign reg_full   = (count_ff >= CntBits'(MaxBodies));
   assign reg_ok     = acc && (req_tuser == OpRegister) && !reg_full;
   assign issue      = adv && busy_ff && (cnt_ff <= CntBits'(MaxBodies));
   assign shift      = issue && (cnt_ff < CntBits'(MaxBodies));

   always_comb begin
      tok_in      = '0;
      tok_in.live = issue && (cnt_ff < n_ff);
      tok_in.fin  = issue && (cnt_ff == CntBits'(MaxBodies));
      tok_in.idx  = cnt_ff[IdxBits-1:0];
   end

   // Ring of body cells; cell zero feeds the pair test
   for (genvar g = 0; g < MaxBodies; g++) begin : g_cell
      sbc_cell u_cell (
         .clock     (clock),
         .shift_en  (shift),
         .wr_en     (reg_ok && (count_ff == CntBits'(g))),
         .wr_body   (req_body),
         .next_body (ring[(g + 1) % MaxBodies]),
         .body      (ring[g])
      );
   end

   sbc_pair_test u_test (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .tok_in  (tok_in),
      .probe   (probe_ff),
      .other   (ring[0]),
      .tok_out (tok_out)
   );

   // Next state: table, scan, pending hit and result register
   always_comb begin
      count_in  = count_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      busy_in   = busy_ff;
      probe_in  = probe_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      rv_in     = rv_ff;
      rhit_in   = rhit_ff;
      rovf_in   = rovf_ff;
      rlast_in  = rlast_ff;
      rearly_in = rearly_ff;
      rnew_in   = rnew_ff;
      if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (adv) begin
         rv_in = 1'b0;
         // hold back each hit until the next one shows whether it is the last
         if (tok_out.live && tok_out.hit) begin
            if (pend_v_ff) begin
               rv_in     = 1'b1;
               rhit_in   = 1'b1;
               rovf_in   = 1'b0;
               rlast_in  = 1'b0;
               rearly_in = OutIdxBits'(pend_ff);
               rnew_in   = OutIdxBits'(n_ff);
            end
            pend_v_in = 1'b1;
            pend_in   = tok_out.idx;
         end
         if (tok_out.fin) begin
            rv_in     = 1'b1;
            rhit_in   = pend_v_ff;
            rovf_in   = 1'b0;
            rlast_in  = 1'b1;
            rearly_in = pend_v_ff ? OutIdxBits'(pend_ff) : '0;
            rnew_in   = OutIdxBits'(n_ff);
            pend_v_in = 1'b0;
            busy_in   = 1'b0;
         end
      end
      if (acc) begin
         if (req_tuser == OpClear) begin
            count_in = '0;
         end else if (reg_full) begin
            rv_in     = 1'b1;
            rhit_in   = 1'b0;
            rovf_in   = 1'b1;
            rlast_in  = 1'b1;
            rearly_in = '0;
            rnew_in   = '0;
         end else begin
            probe_in = req_body;
            n_in     = count_ff;
            count_in = count_ff + 1'b1;
            cnt_in   = '0;
            busy_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cnt_ff    <= '0;
         busy_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         count_ff  <= count_in;
         cnt_ff    <= cnt_in;
         busy_ff   <= busy_in;
         pend_v_ff <= pend_v_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      probe_ff  <= probe_in;
      pend_ff   <= pend_in;
      rhit_ff   <= rhit_in;
      rovf_ff   <= rovf_in;
      rlast_ff  <= rlast_in;
      rearly_ff <= rearly_in;
      rnew_ff   <= rnew_in;
   end

   // Drive the result channel
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = RspDataBits'({rnew_ff, rearly_ff});
   assign rsp_tuser  = {rovf_ff, rhit_ff};
   assign rsp_tlast  = rlast_ff;

endmodule
